FILE: sv/sktcp_pkg.sv
// Shared types and constants for the serial key and time command parser.
// No dependencies; imported by the top module, sktcp_decode and sktcp_out_stage.
package sktcp_pkg;

    // Received character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UP    = 8'h41;
    localparam logic [7:0] CH_DOWN  = 8'h42;
    localparam logic [7:0] CH_RIGHT = 8'h43;
    localparam logic [7:0] CH_LEFT  = 8'h44;
    localparam logic [7:0] CH_END   = 8'h45;
    localparam logic [7:0] CH_TIME  = 8'h54;

    // Key event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_SELECT = 3'd1;
    localparam logic [2:0] EV_UP     = 3'd2;
    localparam logic [2:0] EV_DOWN   = 3'd3;
    localparam logic [2:0] EV_LEFT   = 3'd4;
    localparam logic [2:0] EV_RIGHT  = 3'd5;
    localparam logic [2:0] EV_HALT   = 3'd6;

    localparam int unsigned OUT_TDATA_W = 32;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_HOUR_T = 8'b0000_0010,
        PH_HOUR_U = 8'b0000_0100,
        PH_MIN_T  = 8'b0000_1000,
        PH_MIN_U  = 8'b0001_0000,
        PH_SEC_T  = 8'b0010_0000,
        PH_SEC_U  = 8'b0100_0000,
        PH_CLOSE  = 8'b1000_0000
    } phase_t;

    // One result item
    typedef struct packed {
        logic [7:0] new_second;
        logic [7:0] new_minute;
        logic [7:0] new_hour;
        logic       time_valid;
        logic       key_seen;
        logic [2:0] key_event;
    } res_t;

    // Ten times a digit, modulo 256
    function automatic logic [7:0] tens_of(input logic [7:0] d);
        tens_of = {d[4:0], 3'b000} + {d[6:0], 1'b0};
    endfunction

endpackage

FILE: sv/serial_key_and_time_command_parser.sv
// Serial key and time command parser.
//
// Slave channel s_axis_* takes one received character per transfer. Master
// channel m_axis_* gives exactly one result per character: key event, seen
// flag and, when a 'T' + six digits + 'E' sequence closes, the new time.
// Bytes inside a time sequence give empty results with key_seen low.
//
// Path: a byte accepted on s_axis goes through the input register, the decode
// and the result register before its result appears on m_axis.
// Throughput: one byte per cycle while the sink keeps m_axis_tready high; the
// parser state (phase and three accumulators) updates in the same cycle that a
// byte moves from the input register into the result register.
// Reset: both registers empty, parser idle, accumulators zero.
// Stall: a held result keeps m_axis stable; the input register still takes
// one more byte, after which s_axis_tready drops until the sink resumes.
// Depends on sktcp_pkg, sktcp_in_stage, sktcp_decode, sktcp_out_stage.
module serial_key_and_time_command_parser
    import sktcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [2:0] key_event, [3] key_seen, [4] time_valid, [12:5] new_hour,
    // [20:13] new_minute, [28:21] new_second, [31:29] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       can_load;
    logic       advance;
    res_t       result;

    assign advance = byte_valid && can_load;

    sktcp_in_stage u_in
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data)
    );

    sktcp_decode u_dec
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .rx_byte (byte_data),
        .result  (result)
    );

    sktcp_out_stage u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .result        (result),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // A key event only comes from the idle path
    a_event_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] != EV_NONE) |-> m_axis_tdata[3])
        else $error("key event without key_seen");

    // A closed time sequence is never on the idle path
    a_time_not_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tdata[3])
        else $error("time_valid together with key_seen");

    // Time fields are zero without time_valid
    a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[4]) |-> (m_axis_tdata[28:5] == '0))
        else $error("time fields set without time_valid");

    // A result is loaded only when a byte is consumed
    a_load_follows_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(byte_valid))
        else $error("result appeared without a decoded byte");

endmodule

FILE: sv/sktcp_in_stage.sv
// Input register of the parser: holds one received byte until it is decoded.
// Depends on nothing but the clock and reset.
module sktcp_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       advance,        // held byte moves on this cycle
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign s_axis_tready = !valid_reg || advance;
    assign byte_valid    = valid_reg;
    assign byte_data     = byte_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    // Byte payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            byte_reg <= s_axis_tdata;
        end
    end

endmodule

FILE: sv/sktcp_decode.sv
// Parser state and byte decode: key mapping and time-set accumulation.
// Depends on sktcp_pkg.
module sktcp_decode
    import sktcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,      // byte is consumed this cycle
    input  logic [7:0] rx_byte,
    output res_t       result
);

    phase_t     phase_reg, phase_next;
    logic [7:0] hour_reg, hour_next;
    logic [7:0] minute_reg, minute_next;
    logic [7:0] second_reg, second_next;
    logic [7:0] digit;

    assign digit = rx_byte - CH_ZERO;

    // Next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        result      = '0;
        case (phase_reg)
            PH_HOUR_T:
            begin
                hour_next  = tens_of(digit);
                phase_next = PH_HOUR_U;
            end
            PH_HOUR_U:
            begin
                hour_next  = hour_reg + digit;
                phase_next = PH_MIN_T;
            end
            PH_MIN_T:
            begin
                minute_next = tens_of(digit);
                phase_next  = PH_MIN_U;
            end
            PH_MIN_U:
            begin
                minute_next = minute_reg + digit;
                phase_next  = PH_SEC_T;
            end
            PH_SEC_T:
            begin
                second_next = tens_of(digit);
                phase_next  = PH_SEC_U;
            end
            PH_SEC_U:
            begin
                second_next = second_reg + digit;
                phase_next  = PH_CLOSE;
            end
            PH_CLOSE:
            begin
                phase_next = PH_IDLE;
                if (rx_byte == CH_END)
                begin
                    result.time_valid = 1'b1;
                    result.new_hour   = hour_reg;
                    result.new_minute = minute_reg;
                    result.new_second = second_reg;
                end
            end
            default:
            begin
                // idle path: every byte counts as seen
                result.key_seen = 1'b1;
                case (rx_byte)
                    CH_CR:    result.key_event = EV_SELECT;
                    CH_UP:    result.key_event = EV_UP;
                    CH_DOWN:  result.key_event = EV_DOWN;
                    CH_LEFT:  result.key_event = EV_LEFT;
                    CH_RIGHT: result.key_event = EV_RIGHT;
                    CH_SPACE: result.key_event = EV_HALT;
                    CH_TIME:  phase_next = PH_HOUR_T;
                    default:  result.key_event = EV_NONE;
                endcase
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

endmodule

FILE: sv/sktcp_out_stage.sv
// Result register of the parser: holds one result until the sink takes it.
// Depends on sktcp_pkg.
module sktcp_out_stage
    import sktcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,       // new result this cycle
    input  res_t                   result,
    output logic                   can_load,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic valid_reg;
    res_t data_reg;

    assign can_load      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, data_reg};

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            data_reg <= result;
        end
    end

endmodule

FILE: tb/serial_key_and_time_command_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for serial_key_and_time_command_parser: streams bytes
// in, predicts every result in a scoreboard class and checks the output stream.
// Depends on sktcp_pkg and the parser RTL.
module serial_key_and_time_command_parser_tb;
    import sktcp_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1750;
    localparam int unsigned QUIET_TAIL   = 150;
    localparam int unsigned LONG_HOLD    = 80;
    localparam int unsigned DRAIN_LIMIT  = 5000;

    // Predicts the parser output for each accepted byte and checks results
    class key_time_checker;
        phase_t     phase;
        logic [7:0] hour_acc;
        logic [7:0] minute_acc;
        logic [7:0] second_acc;
        res_t       expected_results[$];
        int         mismatches;
        int         results_seen;
        int         keys_seen;
        int         times_seen;

        function new();
            phase        = PH_IDLE;
            hour_acc     = '0;
            minute_acc   = '0;
            second_acc   = '0;
            mismatches   = 0;
            results_seen = 0;
            keys_seen    = 0;
            times_seen   = 0;
        endfunction

        // Advance the parser state by one byte and queue its result
        function void note_byte(logic [7:0] b);
            res_t       r;
            logic [7:0] d;
            r = '0;
            d = b - CH_ZERO;
            case (phase)
                PH_IDLE:
                begin
                    r.key_seen = 1'b1;
                    case (b)
                        CH_CR:    r.key_event = EV_SELECT;
                        CH_UP:    r.key_event = EV_UP;
                        CH_DOWN:  r.key_event = EV_DOWN;
                        CH_LEFT:  r.key_event = EV_LEFT;
                        CH_RIGHT: r.key_event = EV_RIGHT;
                        CH_SPACE: r.key_event = EV_HALT;
                        CH_TIME:  phase = PH_HOUR_T;
                        default:  ;
                    endcase
                end
                PH_HOUR_T:
                begin
                    hour_acc = d * 8'd10;
                    phase    = PH_HOUR_U;
                end
                PH_HOUR_U:
                begin
                    hour_acc = hour_acc + d;
                    phase    = PH_MIN_T;
                end
                PH_MIN_T:
                begin
                    minute_acc = d * 8'd10;
                    phase      = PH_MIN_U;
                end
                PH_MIN_U:
                begin
                    minute_acc = minute_acc + d;
                    phase      = PH_SEC_T;
                end
                PH_SEC_T:
                begin
                    second_acc = d * 8'd10;
                    phase      = PH_SEC_U;
                end
                PH_SEC_U:
                begin
                    second_acc = second_acc + d;
                    phase      = PH_CLOSE;
                end
                default:
                begin
                    // closing byte; anything but 'E' drops the sequence
                    phase = PH_IDLE;
                    if (b == CH_END)
                    begin
                        r.time_valid = 1'b1;
                        r.new_hour   = hour_acc;
                        r.new_minute = minute_acc;
                        r.new_second = second_acc;
                    end
                end
            endcase
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t: mismatch on %s, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        // Compare one output transfer with the oldest prediction
        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            res_t want;
            res_t got;
            got = res_t'(tdata[28:0]);
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, expected none, actual 0x%08h",
                         $time, tdata);
                return;
            end
            want = expected_results.pop_front();
            results_seen++;
            if (want.key_event != EV_NONE)
                keys_seen++;
            if (want.time_valid)
                times_seen++;
            compare_field("key_event",  want.key_event,  got.key_event);
            compare_field("key_seen",   want.key_seen,   got.key_seen);
            compare_field("time_valid", want.time_valid, got.time_valid);
            compare_field("new_hour",   want.new_hour,   got.new_hour);
            compare_field("new_minute", want.new_minute, got.new_minute);
            compare_field("new_second", want.new_second, got.new_second);
            compare_field("padding",    0,               tdata[31:29]);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [2:0] key_event, [3] key_seen, [4] time_valid, [12:5] new_hour,
    // [20:13] new_minute, [28:21] new_second, [31:29] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    key_time_checker checker_h;
    bit              idling_on;
    bit              long_hold_req;
    int unsigned     bytes_sent;

    serial_key_and_time_command_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    initial
        clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Overall time limit
    initial
    begin
        #2_000_000;
        $display("FAIL serial_key_and_time_command_parser");
        $finish;
    end

    // Sink side: random back-pressure bursts and one long hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            checker_h.check_result(m_axis_tdata);
    end

    // Offer one byte, starting and ending on a falling edge
    task automatic send_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        checker_h.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // 'T', six digits (now and then a stray byte) and a closing byte
    task automatic send_time_sequence();
        logic [7:0] b;
        send_byte(CH_TIME);
        repeat (6)
        begin
            if ($urandom_range(0, 9) == 0)
                b = 8'($urandom);
            else
                b = CH_ZERO + 8'($urandom_range(0, 9));
            send_byte(b);
        end
        if ($urandom_range(0, 6) == 0)
            b = 8'($urandom);
        else
            b = CH_END;
        send_byte(b);
    endtask

    task automatic send_key();
        case ($urandom_range(0, 5))
            0:       send_byte(CH_CR);
            1:       send_byte(CH_UP);
            2:       send_byte(CH_DOWN);
            3:       send_byte(CH_LEFT);
            4:       send_byte(CH_RIGHT);
            default: send_byte(CH_SPACE);
        endcase
    endtask

    // Stimulus and end of run
    initial
    begin
        int unsigned waited;
        bit          hold_done;
        checker_h     = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idling_on     = 1'b1;
        long_hold_req = 1'b0;
        bytes_sent    = 0;
        hold_done     = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every key, an unknown idle byte
        send_byte(CH_CR);
        send_byte(CH_UP);
        send_byte(CH_DOWN);
        send_byte(CH_LEFT);
        send_byte(CH_RIGHT);
        send_byte(CH_SPACE);
        send_byte(8'hFF);
        // Sequence closed by something other than 'E'
        send_byte(CH_TIME);
        send_byte("2");
        send_byte("3");
        send_byte("5");
        send_byte("9");
        send_byte("5");
        send_byte("9");
        send_byte(8'h00);
        // Non-digit bytes through the digit arithmetic, closed by 'E'
        send_byte(CH_TIME);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte("9");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(CH_END);

        // Random: time sequences (some with stray bytes), keys and noise bytes
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent >= RANDOM_BYTES - QUIET_TAIL)
                idling_on = 1'b0;
            if (!hold_done && bytes_sent >= 500)
            begin
                long_hold_req = 1'b1;
                hold_done     = 1'b1;
            end
            case ($urandom_range(0, 3))
                0, 1:    send_time_sequence();
                2:       send_key();
                default: send_byte(8'($urandom));
            endcase
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow for the pipeline latency
        waited = 0;
        while (checker_h.expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (checker_h.expected_results.size() != 0)
        begin
            checker_h.mismatches++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, checker_h.expected_results.size());
        end

        $display("Run covered %0d bytes and %0d results: %0d key events, %0d times set.",
                 bytes_sent, checker_h.results_seen, checker_h.keys_seen,
                 checker_h.times_seen);
        if (checker_h.mismatches == 0)
            $display("PASS serial_key_and_time_command_parser");
        else
            $display("FAIL serial_key_and_time_command_parser");
        $finish;
    end

endmodule
